// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/tot_pkg.sv
// ----------------------------------------------------------------------------
// tot_pkg
// Types and constants shared by the triangle overlap test blocks.
// ----------------------------------------------------------------------------
package tot_pkg;

  // port width of every coordinate field
  localparam int unsigned IN_BITS  = 16;
  // width of the tolerance register
  localparam int unsigned TOL_BITS = 35;
  // coordinates per request (two triangles, three vertices, x and y)
  localparam int unsigned NUM_CRD  = 12;
  // queue between front and back
  localparam int unsigned Q_DEPTH  = 4;
  localparam int unsigned Q_PW     = 2;
  localparam int unsigned Q_CW     = 3;
  // accepting edge to result strobe
  localparam int unsigned LATENCY  = 7;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_EDGE_TOL  = 2'd0,
    CFG_ALLOW_REV = 2'd1,
    CFG_TOUCH     = 2'd2
  } cfg_idx_e;

  // configuration as seen by the datapath
  typedef struct packed {
    logic signed [TOL_BITS-1:0] tol;
    logic                       allow_rev;
    logic                       touch;
  } cfg_t;

  // queue status seen by the front
  typedef struct packed {
    logic [Q_CW-1:0] cnt;
    logic            empty;
  } q_stat_t;

endpackage

// File: design/tot_front.sv
// ----------------------------------------------------------------------------
// tot_front
// Accepts requests, finds each triangle's orientation and classifies it:
// clockwise triangles are swapped or flagged, then pushed to the queue.
// ----------------------------------------------------------------------------
module tot_front import tot_pkg::*; #(
  parameter int unsigned C = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  output logic                   busy_o,
  input  logic [IN_BITS-1:0]     raw_i [NUM_CRD],
  input  cfg_t                   cfg_i,
  input  q_stat_t                q_stat_i,
  output logic                   push_o,
  output logic [NUM_CRD*C:0]     push_data_o
);

  localparam int unsigned PW = 2 * C + 2;
  localparam int unsigned DW = 2 * C + 3;

  logic                v1_q, v2_q;
  logic signed [C-1:0] c1_q [NUM_CRD];
  logic signed [C-1:0] c2_q [NUM_CRD];
  logic signed [PW-1:0] pa_d [2], pb_d [2];
  logic signed [PW-1:0] pa_q [2], pb_q [2];
  logic                accept;
  logic [Q_CW-1:0]     inflight;

  // credit check: queue entries plus requests still in the front
  assign inflight = q_stat_i.cnt + Q_CW'(v1_q) + Q_CW'(v2_q);
  assign busy_o   = (inflight >= Q_CW'(Q_DEPTH));
  assign accept   = start_i && !busy_o;

  // stage 1: capture coordinates, sign-extended or truncated to C bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_CRD; k++) begin
      c1_q[k] <= C'($signed({{24{raw_i[k][IN_BITS-1]}}, raw_i[k]}));
    end
  end

  // orientation products (v1 - v0) x (v2 - v0)
  always_comb begin
    logic signed [C:0] ex1, ey1, ex2, ey2;
    for (int t = 0; t < 2; t++) begin
      ex1 = (C+1)'(c1_q[6*t+2]) - (C+1)'(c1_q[6*t+0]);
      ey1 = (C+1)'(c1_q[6*t+3]) - (C+1)'(c1_q[6*t+1]);
      ex2 = (C+1)'(c1_q[6*t+4]) - (C+1)'(c1_q[6*t+0]);
      ey2 = (C+1)'(c1_q[6*t+5]) - (C+1)'(c1_q[6*t+1]);
      pa_d[t] = ex1 * ey2;
      pb_d[t] = ey1 * ex2;
    end
  end

  // stage 2: products registered
  always_ff @(posedge clk_i) begin
    c2_q <= c1_q;
    pa_q <= pa_d;
    pb_q <= pb_d;
  end

  // classify: swap vertices 1 and 2 of a clockwise triangle, or flag it
  always_comb begin
    logic signed [DW-1:0] det;
    logic                 neg;
    logic                 err;
    logic signed [C-1:0]  crd [NUM_CRD];
    err = 1'b0;
    crd = c2_q;
    for (int t = 0; t < 2; t++) begin
      det = DW'(pa_q[t]) - DW'(pb_q[t]);
      neg = det[DW-1];
      if (neg && cfg_i.allow_rev) begin
        crd[6*t+2] = c2_q[6*t+4];
        crd[6*t+3] = c2_q[6*t+5];
        crd[6*t+4] = c2_q[6*t+2];
        crd[6*t+5] = c2_q[6*t+3];
      end
      err = err | (neg && !cfg_i.allow_rev);
    end
    for (int k = 0; k < NUM_CRD; k++) begin
      push_data_o[k*C +: C] = crd[k];
    end
    push_data_o[NUM_CRD*C] = err;
  end

  assign push_o = v2_q;

endmodule

// File: design/tot_queue.sv
// ----------------------------------------------------------------------------
// tot_queue
// Short FIFO between the front and the back.
// ----------------------------------------------------------------------------
module tot_queue import tot_pkg::*; #(
  parameter int unsigned W = 193
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  input  logic         pop_i,
  output logic [W-1:0] data_o,
  output q_stat_t      stat_o
);

  logic [W-1:0]    mem_q [Q_DEPTH];
  logic [Q_PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [Q_CW-1:0] cnt_q;
  logic            do_pop;

  assign do_pop = pop_i && (cnt_q != '0);

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      cnt_q <= cnt_q + Q_CW'(push_i) - Q_CW'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= data_i;
  end

  assign data_o       = mem_q[rd_ptr_q];
  assign stat_o.cnt   = cnt_q;
  assign stat_o.empty = (cnt_q == '0);

endmodule

// File: design/tot_back.sv
// ----------------------------------------------------------------------------
// tot_back
// Runs the NTEST edge-side tests of a classified pair in lanes and
// reduces them to the overlap result.
// ----------------------------------------------------------------------------
module tot_back import tot_pkg::*; #(
  parameter int unsigned C = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  logic [NUM_CRD*C:0] data_i,
  input  cfg_t               cfg_i,
  output logic               done_o,
  output logic               overlap_o,
  output logic               winding_error_o
);

  localparam int unsigned PW    = 2 * C + 2;
  localparam int unsigned DW    = 2 * C + 3;
  localparam int unsigned CW    = (DW > TOL_BITS) ? DW : TOL_BITS;
  localparam int unsigned NTEST = 18;

  logic                 v1_q, v2_q, v3_q, done_q;
  logic                 e1_q, e2_q, e3_q;
  logic signed [C-1:0]  c1_q [NUM_CRD];
  logic signed [PW-1:0] p1_d [NTEST], p2_d [NTEST];
  logic signed [PW-1:0] p1_q [NTEST], p2_q [NTEST];
  logic [NTEST-1:0]     out_d, out_q;
  logic                 sep;
  logic                 overlap_q, werr_q;

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= valid_i;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      done_q <= v3_q;
    end
  end

  // stage 1: unpack the popped request
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NUM_CRD; k++) begin
      c1_q[k] <= data_i[k*C +: C];
    end
    e1_q <= data_i[NUM_CRD*C];
  end

  // lane n = 9*e + 3*i + k: edge i of triangle e against vertex k of the other
  always_comb begin
    int oe, oo, j, n;
    logic signed [C:0] dqx, dqy, drx, dry;
    for (int e = 0; e < 2; e++) begin
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          oe  = 6 * e;
          oo  = 6 * (1 - e);
          j   = (i == 2) ? 0 : i + 1;
          n   = 9 * e + 3 * i + k;
          dqx = (C+1)'(c1_q[oe+2*j])   - (C+1)'(c1_q[oe+2*i]);
          dqy = (C+1)'(c1_q[oe+2*j+1]) - (C+1)'(c1_q[oe+2*i+1]);
          drx = (C+1)'(c1_q[oo+2*k])   - (C+1)'(c1_q[oe+2*i]);
          dry = (C+1)'(c1_q[oo+2*k+1]) - (C+1)'(c1_q[oe+2*i+1]);
          p1_d[n] = dqx * dry;
          p2_d[n] = dqy * drx;
        end
      end
    end
  end

  // stage 2: products
  always_ff @(posedge clk_i) begin
    p1_q <= p1_d;
    p2_q <= p2_d;
    e2_q <= e1_q;
  end

  // outside test against the tolerance
  always_comb begin
    logic signed [DW-1:0] det;
    logic signed [CW-1:0] dx, tx;
    tx = CW'($signed(cfg_i.tol));
    for (int n = 0; n < NTEST; n++) begin
      det      = DW'(p1_q[n]) - DW'(p2_q[n]);
      dx       = CW'(det);
      out_d[n] = cfg_i.touch ? (dx < tx) : (dx <= tx);
    end
  end

  // stage 3: outside flags
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    e3_q  <= e2_q;
  end

  // an edge separates when all three vertices are outside it
  always_comb begin
    sep = 1'b0;
    for (int g = 0; g < 6; g++) begin
      sep = sep | (&out_q[3*g +: 3]);
    end
  end

  // stage 4: result registers
  always_ff @(posedge clk_i) begin
    if (v3_q) begin
      overlap_q <= !e3_q && !sep;
      werr_q    <= e3_q;
    end
  end

  assign done_o          = done_q;
  assign overlap_o       = overlap_q;
  assign winding_error_o = werr_q;

endmodule

// File: design/triangle_overlap_test_2d.sv
// Each accepted request passes the front, the queue and the back to done_o.
// Throughput: one request per cycle; the back takes one queue entry a cycle,
// so the queue stays nearly empty and busy_o only rises if it would fill.
// Reset (rst_ni low, asynchronous) empties the pipelines and the queue and
// sets edge_tolerance = 0, allow_reversed = 0, touch_counts = 1.
// ----------------------------------------------------------------------------
// triangle_overlap_test_2d
// 2D triangle pair overlap by separating edges: front classifies winding,
// a short queue decouples it from the back, which runs the edge tests.
// ----------------------------------------------------------------------------
module triangle_overlap_test_2d import tot_pkg::*; #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [IN_BITS-1:0]  tri_a_x0_i,
  input  logic [IN_BITS-1:0]  tri_a_y0_i,
  input  logic [IN_BITS-1:0]  tri_a_x1_i,
  input  logic [IN_BITS-1:0]  tri_a_y1_i,
  input  logic [IN_BITS-1:0]  tri_a_x2_i,
  input  logic [IN_BITS-1:0]  tri_a_y2_i,
  input  logic [IN_BITS-1:0]  tri_b_x0_i,
  input  logic [IN_BITS-1:0]  tri_b_y0_i,
  input  logic [IN_BITS-1:0]  tri_b_x1_i,
  input  logic [IN_BITS-1:0]  tri_b_y1_i,
  input  logic [IN_BITS-1:0]  tri_b_x2_i,
  input  logic [IN_BITS-1:0]  tri_b_y2_i,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [TOL_BITS-1:0] cfg_wdata_i,
  output logic                done_o,
  output logic                overlap_o,
  output logic                winding_error_o
);

  localparam int unsigned EW = NUM_CRD * COORD_BITS + 1;

  logic [IN_BITS-1:0] raw [NUM_CRD];
  cfg_t               cfg_q;
  q_stat_t            q_stat;
  logic               push;
  logic [EW-1:0]      push_data, pop_data;

  assign raw[0]  = tri_a_x0_i;
  assign raw[1]  = tri_a_y0_i;
  assign raw[2]  = tri_a_x1_i;
  assign raw[3]  = tri_a_y1_i;
  assign raw[4]  = tri_a_x2_i;
  assign raw[5]  = tri_a_y2_i;
  assign raw[6]  = tri_b_x0_i;
  assign raw[7]  = tri_b_y0_i;
  assign raw[8]  = tri_b_x1_i;
  assign raw[9]  = tri_b_y1_i;
  assign raw[10] = tri_b_x2_i;
  assign raw[11] = tri_b_y2_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tol       <= '0;
      cfg_q.allow_rev <= 1'b0;
      cfg_q.touch     <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_EDGE_TOL:  cfg_q.tol       <= cfg_wdata_i;
        CFG_ALLOW_REV: cfg_q.allow_rev <= cfg_wdata_i[0];
        CFG_TOUCH:     cfg_q.touch     <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  tot_front #(.C(COORD_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .raw_i       (raw),
    .cfg_i       (cfg_q),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  tot_queue #(.W(EW)) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (push_data),
    .pop_i  (!q_stat.empty),
    .data_o (pop_data),
    .stat_o (q_stat)
  );

  tot_back #(.C(COORD_BITS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (!q_stat.empty),
    .data_i          (pop_data),
    .cfg_i           (cfg_q),
    .done_o          (done_o),
    .overlap_o       (overlap_o),
    .winding_error_o (winding_error_o)
  );

endmodule

// File: design/tot_checker.sv
// ----------------------------------------------------------------------------
// tot_checker
// Port-level checks of the overlap test: request-to-result timing and
// consistency of the result flags.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tot_sva import tot_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_i,
  input logic done_i,
  input logic overlap_i,
  input logic winding_error_i
);

  // every accepted request yields a result after the fixed latency
  `ASSERT_IMP(a_req_to_done, clk_i, rst_ni, start_i && !busy_i, ##LATENCY done_i)

  // no result without a request accepted at the matching edge
  `ASSERT_IMP(a_done_has_req, clk_i, rst_ni, done_i, $past(start_i && !busy_i, LATENCY))

  // a rejected winding never reports overlap
  `ASSERT_IMP(a_err_no_overlap, clk_i, rst_ni, done_i && winding_error_i, !overlap_i)

  // the back drains a request each cycle, so the queue never backs up
  `ASSERT_NXT(a_never_busy, clk_i, rst_ni, 1'b1, !busy_i)

endmodule

bind triangle_overlap_test_2d tot_sva u_tot_sva (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .start_i         (start),
  .busy_i          (busy),
  .done_i          (done_o),
  .overlap_i       (overlap_o),
  .winding_error_i (winding_error_o)
);
